FILE: src/bbfm_pkg.sv
// Shared types, register indexes, reset values and fixed-point helpers for the
// bouncing ball floor model. No dependencies.
package bbfm_pkg;

    localparam int QW      = 40;   // Q7.32 state and payload width
    localparam int WIDE_W  = 48;   // headroom for sums and scaled products
    localparam int CFG_IW  = 3;    // configuration register index width

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_GRAVITY_STEP   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_DAMPING_FACTOR = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_STICK_RADIUS   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SETTLE_RADIUS  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_VELOCITY_LIMIT = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_BLEND_RATE     = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_DITHER_SCALE   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [33:0] DAMPING_RESET  = 34'd4294967296;
    localparam logic [38:0] VEL_LIM_RESET  = 39'd89478;
    localparam logic [32:0] BLEND_RESET    = 33'd89478;

    localparam logic signed [WIDE_W-1:0] Q_MAX_W = 48'sd549755813887;
    localparam logic signed [WIDE_W-1:0] Q_MIN_W = -48'sd549755813888;

    typedef struct packed {
        logic signed [QW-1:0] gravity_step;
        logic [33:0]          damping_factor;
        logic [38:0]          stick_radius;
        logic [38:0]          settle_radius;
        logic [38:0]          velocity_limit;
        logic [32:0]          blend_rate;
        logic [38:0]          dither_scale;
    } cfg_t;

    typedef struct packed {
        logic signed [QW-1:0] position;
        logic signed [QW-1:0] velocity;
        logic signed [QW-1:0] previous_floor;
    } ball_state_t;

    // Clamp a wide signed value to the 40-bit signed range.
    function automatic logic signed [QW-1:0] sat40(input logic signed [WIDE_W-1:0] v);
        logic signed [QW-1:0] r;
        if (v > Q_MAX_W) begin
            r = Q_MAX_W[QW-1:0];
        end else if (v < Q_MIN_W) begin
            r = Q_MIN_W[QW-1:0];
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    // floor(a * b / 2^32) built from three partial products. The low halves
    // meet in a 32 x 32 product whose fraction is dropped; the signed high
    // part of a and the two high bits of b contribute whole multiples.
    function automatic logic signed [WIDE_W-1:0] mulq32(input logic signed [43:0] a,
                                                        input logic [33:0] b);
        logic [31:0]              al;
        logic signed [11:0]       ah;
        logic [31:0]              bl;
        logic [1:0]               bh;
        logic [63:0]              lo;
        logic signed [WIDE_W-1:0] t_lo;
        logic signed [WIDE_W-1:0] t_ah;
        logic signed [WIDE_W-1:0] t_bh;
        al   = a[31:0];
        ah   = a[43:32];
        bl   = b[31:0];
        bh   = b[33:32];
        lo   = al * bl;
        t_lo = $signed({16'b0, lo[63:32]});
        t_ah = WIDE_W'(ah) * $signed({15'b0, 1'b0, bl});
        t_bh = WIDE_W'(a) * $signed({46'b0, bh});
        return t_lo + t_ah + t_bh;
    endfunction

endpackage

FILE: src/bouncing_ball_floor_model_unit.sv
// Bouncing ball over a moving floor: top level with handshakes and state.
// An accepted word waits in the input stage; its new position then lands in the output register.
// Throughput: one word per cycle while m_ready is high; one registered pass from input stage to output.
// Reset (aresetn low, synchronous): stages empty, ball state zero, registers at defaults.
// Depends on bbfm_pkg and bbfm_update.
module bouncing_ball_floor_model_unit
    import bbfm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration write port.
    input  logic                     cfg_wr_en,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [QW-1:0]            cfg_wdata,
    // Input word: floor sample, random fraction and start flag.
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [QW-1:0]     s_floor_height,
    input  logic [31:0]              s_random_fraction,
    input  logic                     s_start_req,
    // Result word: ball position.
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [QW-1:0]     m_ball_position
);

    // Configuration registers; the user must write them only while the unit is idle, as the block does not enforce it.
    cfg_t                 cfg_reg;

    // Input stage: holds one accepted word until the update stage takes it.
    logic                 in_valid_reg;
    logic signed [QW-1:0] in_floor_reg;
    logic [31:0]          in_rand_reg;
    logic                 in_start_reg;

    // Ball state and the output register.
    ball_state_t          state_reg;
    ball_state_t          state_next;
    logic                 out_valid_reg;
    logic signed [QW-1:0] out_pos_reg;

    logic                 out_free;
    logic                 advance;
    logic                 s_accept;

    // The output register frees up when it is empty or being read this cycle.
    // The update pass fires whenever the input stage holds a word and the
    // output register can take its result, so the two sides never lock step.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    assign m_valid         = out_valid_reg;
    assign m_ball_position = out_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gravity_step   <= '0;
            cfg_reg.damping_factor <= DAMPING_RESET;
            cfg_reg.stick_radius   <= '0;
            cfg_reg.settle_radius  <= '0;
            cfg_reg.velocity_limit <= VEL_LIM_RESET;
            cfg_reg.blend_rate     <= BLEND_RESET;
            cfg_reg.dither_scale   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GRAVITY_STEP:   cfg_reg.gravity_step   <= $signed(cfg_wdata);
                CFG_DAMPING_FACTOR: cfg_reg.damping_factor <= cfg_wdata[33:0];
                CFG_STICK_RADIUS:   cfg_reg.stick_radius   <= cfg_wdata[38:0];
                CFG_SETTLE_RADIUS:  cfg_reg.settle_radius  <= cfg_wdata[38:0];
                CFG_VELOCITY_LIMIT: cfg_reg.velocity_limit <= cfg_wdata[38:0];
                CFG_BLEND_RATE:     cfg_reg.blend_rate     <= cfg_wdata[32:0];
                CFG_DITHER_SCALE:   cfg_reg.dither_scale   <= cfg_wdata[38:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Input stage control and payload. The payload needs no reset since
    // in_valid_reg qualifies it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_floor_reg <= s_floor_height;
            in_rand_reg  <= s_random_fraction;
            in_start_reg <= s_start_req;
        end
    end

    bbfm_update u_update (
        .cfg             (cfg_reg),
        .cur             (state_reg),
        .floor_height    (in_floor_reg),
        .random_fraction (in_rand_reg),
        .start_req       (in_start_reg),
        .nxt             (state_next)
    );

    // Ball state and the output register move together, so the word shown on
    // the output is always the position the state holds.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_pos_reg <= state_next.position;
        end
    end

`ifndef SYNTHESIS
    // An update pass always leaves a result waiting in the output register.
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("update pass did not fill the output register");

    // A full input stage behind a stalled output must hold off new words.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are blocked");

    // The shown word matches the ball state it came from.
    a_out_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_pos_reg == state_reg.position))
        else $error("output word differs from ball position state");
`endif

endmodule

FILE: src/bbfm_update.sv
// One-sample update of the ball: gravity, floor velocity clip, stick/settle,
// blend and bounce. Purely combinational; depends on bbfm_pkg.
module bbfm_update
    import bbfm_pkg::*;
(
    input  cfg_t                 cfg,
    input  ball_state_t          cur,
    input  logic signed [QW-1:0] floor_height,
    input  logic [31:0]          random_fraction,
    input  logic                 start_req,
    output ball_state_t          nxt
);

    logic signed [QW-1:0]     pos0;
    logic signed [QW-1:0]     vel0;
    logic signed [QW-1:0]     pf0;
    logic signed [QW-1:0]     vel1;
    logic signed [QW-1:0]     pos1;
    logic signed [QW:0]       offset;
    logic [QW:0]              adist;
    logic signed [QW:0]       fvel_raw;
    logic signed [QW:0]       lim_s;
    logic signed [QW:0]       fvel;
    logic signed [QW+1:0]     vdiff;
    logic signed [QW:0]       gap;
    logic signed [WIDE_W-1:0] blend_v;
    logic signed [WIDE_W-1:0] blend_p;
    logic signed [WIDE_W-1:0] damped;
    logic signed [WIDE_W-1:0] dith;

    always_comb begin
        // A start word reloads the ball at the floor with no velocity.
        pos0 = start_req ? floor_height : cur.position;
        pf0  = start_req ? floor_height : cur.previous_floor;
        vel0 = start_req ? '0 : cur.velocity;

        vel1 = sat40(WIDE_W'(vel0) - WIDE_W'(cfg.gravity_step));
        pos1 = sat40(WIDE_W'(pos0) + WIDE_W'(vel1));
        offset = (QW+1)'(pos1) - (QW+1)'(floor_height);
        adist = offset[QW] ? (QW+1)'(-offset) : (QW+1)'(offset);

        fvel_raw = (QW+1)'(floor_height) - (QW+1)'(pf0);
        lim_s    = $signed({2'b0, cfg.velocity_limit});
        if (fvel_raw > lim_s) begin
            fvel = lim_s;
        end else if (fvel_raw < -lim_s) begin
            fvel = -lim_s;
        end else begin
            fvel = fvel_raw;
        end
        vdiff = (QW+2)'(fvel) - (QW+2)'(vel1);
        gap   = (QW+1)'(floor_height) - (QW+1)'(pos1);

        blend_v = mulq32(44'(vdiff), {1'b0, cfg.blend_rate});
        blend_p = mulq32(44'(gap), {1'b0, cfg.blend_rate});
        damped  = mulq32(44'(vdiff), cfg.damping_factor);
        dith    = mulq32($signed({5'b0, cfg.dither_scale}), {2'b0, random_fraction});

        nxt.previous_floor = floor_height;
        if (adist < {2'b0, cfg.stick_radius}) begin
            if (adist < {2'b0, cfg.settle_radius}) begin
                nxt.velocity = '0;
                nxt.position = sat40(WIDE_W'(floor_height) + WIDE_W'(cfg.gravity_step));
            end else begin
                nxt.velocity = sat40(WIDE_W'(vel1) + blend_v);
                nxt.position = sat40(WIDE_W'(pos1) + blend_p);
            end
        end else if (offset <= 0) begin
            nxt.position = sat40(WIDE_W'(floor_height) - WIDE_W'(offset));
            nxt.velocity = sat40(damped + dith);
        end else begin
            nxt.position = pos1;
            nxt.velocity = vel1;
        end
    end

endmodule
